// ----- src/cfpsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpsd_pkg
// Shared types, constants and the sensor pattern decode of the frame parser.
// ----------------------------------------------------------------------------
package cfpsd_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int SENS_N      = 4;
  localparam int PAT_N       = 7;
  localparam int DISP_W      = 15;
  localparam int STEER_W     = 3;

  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'hA6;
  localparam logic [7:0] TRAILER    = 8'h5B;

  // frame positions of the sensor bytes, in order byte2, byte3, byte5, byte6
  localparam int SENS_IDX [SENS_N] = '{2, 3, 5, 6};

  localparam logic [7:0] PAT_B2 [PAT_N] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1};
  localparam logic [7:0] PAT_B3 [PAT_N] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1};
  localparam logic [7:0] PAT_B5 [PAT_N] = '{8'd0, 8'd1, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] PAT_B6 [PAT_N] = '{8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0};

  localparam logic signed [STEER_W-1:0] PAT_STEER [PAT_N] =
    '{3'sb000, 3'sb111, 3'sb110, 3'sb101, 3'sb001, 3'sb010, 3'sb011};

  localparam logic [DISP_W-1:0] PAT_DISP [PAT_N] =
    '{15'd22222, 15'd22212, 15'd22221, 15'd22211, 15'd21222, 15'd12222, 15'd11222};

  typedef struct packed {
    logic       good;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b5;
    logic [7:0] b6;
  } job_t;

  typedef struct packed {
    logic                       hit;
    logic signed [STEER_W-1:0]  steer;
    logic [DISP_W-1:0]          disp;
  } match_t;

  function automatic match_t pat_match(job_t j);
    match_t m;
    m = '0;
    for (int k = PAT_N - 1; k >= 0; k--) begin
      if (j.b2 == PAT_B2[k] && j.b3 == PAT_B3[k] &&
          j.b5 == PAT_B5[k] && j.b6 == PAT_B6[k]) begin
        m.hit   = 1'b1;
        m.steer = PAT_STEER[k];
        m.disp  = PAT_DISP[k];
      end
    end
    return m;
  endfunction

endpackage

// ----- src/cfpsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpsd_front
// Header hunt and frame capture; emits one frame job on each judging byte.
// ----------------------------------------------------------------------------
module cfpsd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_rx_byte,
  input  logic             q_full,
  output logic             push,
  output cfpsd_pkg::job_t  push_job
);
  import cfpsd_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_HDR2  = 4'b0010,
    PH_FILL  = 4'b0100,
    PH_JUDGE = 4'b1000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sens_r [SENS_N];
  logic [7:0]       sens_nxt [SENS_N];
  logic             trl_r, trl_nxt;
  logic             acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    trl_nxt   = trl_r;
    sens_nxt  = sens_r;
    push      = 1'b0;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == HDR_FIRST) begin
            phase_nxt = PH_HDR2;
            cnt_nxt   = CNT_W'(1);
          end else begin
            cnt_nxt = '0;
          end
        end
        PH_HDR2: begin
          if (in_rx_byte == HDR_SECOND) begin
            phase_nxt = PH_FILL;
            cnt_nxt   = CNT_W'(2);
          end else begin
            phase_nxt = PH_HUNT;
            cnt_nxt   = '0;
            for (int j = 0; j < SENS_N; j++) sens_nxt[j] = '0;
          end
        end
        PH_FILL: begin
          for (int j = 0; j < SENS_N; j++) begin
            if (cnt_r == CNT_W'(SENS_IDX[j])) sens_nxt[j] = in_rx_byte;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
          trl_nxt = (in_rx_byte == TRAILER);
          if (cnt_nxt == CNT_W'(FRAME_BYTES) || in_rx_byte == TRAILER) begin
            phase_nxt = PH_JUDGE;
          end
        end
        PH_JUDGE: begin
          push      = 1'b1;
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
          for (int j = 0; j < SENS_N; j++) sens_nxt[j] = '0;
        end
        default: begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  assign push_job.good = trl_r;
  assign push_job.b2   = sens_r[0];
  assign push_job.b3   = sens_r[1];
  assign push_job.b5   = sens_r[2];
  assign push_job.b6   = sens_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      trl_r   <= 1'b0;
      for (int j = 0; j < SENS_N; j++) sens_r[j] <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      trl_r   <= trl_nxt;
      sens_r  <= sens_nxt;
    end
  end

endmodule

// ----- src/cfpsd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpsd_queue
// Two-entry queue of frame jobs between capture and decode.
// ----------------------------------------------------------------------------
module cfpsd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cfpsd_pkg::job_t  push_job,
  output logic             full,
  output logic             q_valid,
  input  logic             pop,
  output cfpsd_pkg::job_t  pop_job
);
  import cfpsd_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign pop_job = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 2'd1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- src/cfpsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpsd_back
// Pattern decode, held steering and display codes, and result register.
// ----------------------------------------------------------------------------
module cfpsd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  cfpsd_pkg::job_t                      pop_job,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_frame_good,
  output logic                                 out_pattern_hit,
  output logic signed [cfpsd_pkg::STEER_W-1:0] out_steer_code,
  output logic [cfpsd_pkg::DISP_W-1:0]         out_display_code
);
  import cfpsd_pkg::*;

  match_t                    m;
  logic                      upd;
  logic                      vld_r;
  logic                      good_r;
  logic                      hit_r;
  logic signed [STEER_W-1:0] steer_r, steer_nxt;
  logic [DISP_W-1:0]         disp_r, disp_nxt;

  assign pop       = q_valid && (!vld_r || out_ready);
  assign m         = pat_match(pop_job);
  assign upd       = pop && pop_job.good && m.hit;
  assign steer_nxt = upd ? m.steer : steer_r;
  assign disp_nxt  = upd ? m.disp : disp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      steer_r <= '0;
      disp_r  <= '0;
    end else begin
      if (pop) vld_r <= 1'b1;
      else if (out_ready) vld_r <= 1'b0;
      steer_r <= steer_nxt;
      disp_r  <= disp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      good_r <= pop_job.good;
      hit_r  <= pop_job.good && m.hit;
    end
  end

  assign out_valid        = vld_r;
  assign out_frame_good   = good_r;
  assign out_pattern_hit  = hit_r;
  assign out_steer_code   = steer_r;
  assign out_display_code = disp_r;

endmodule

// ----- src/camera_frame_parser_steer_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_frame_parser_steer_decode
// Byte-stream frame parser with sensor pattern decode into steering codes.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready   rx_byte[7:0]
//   out_     out  out_valid/out_ready frame_good, pattern_hit,
//                                     steer_code[2:0] signed, display_code[14:0]
//
// One byte per cycle while the job queue is not full. A result passes from its
// judging byte through the two-entry job queue, which sits between capture
// and decode, and then the result register when the output is free.
// Synchronous active-low reset clears parser, buffer and held codes. in_ready drops only while the job queue is full.
// ----------------------------------------------------------------------------
module camera_frame_parser_steer_decode (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_frame_good,
  output logic                                 out_pattern_hit,
  output logic signed [cfpsd_pkg::STEER_W-1:0] out_steer_code,
  output logic [cfpsd_pkg::DISP_W-1:0]         out_display_code
);
  import cfpsd_pkg::*;

  logic q_full, q_valid, push, pop;
  job_t push_job, pop_job;

  cfpsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  cfpsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .pop_job  (pop_job)
  );

  cfpsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .pop_job          (pop_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_good   (out_frame_good),
    .out_pattern_hit  (out_pattern_hit),
    .out_steer_code   (out_steer_code),
    .out_display_code (out_display_code)
  );

  a_hit_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pattern_hit |-> out_frame_good)
    else $error("pattern hit on rejected frame");

  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_steer_code != 3'b100)
    else $error("steer code out of range");

  a_disp_zero_straight: assert property (@(posedge clk) disable iff (!rst_n)
    out_display_code == '0 |-> out_steer_code == '0)
    else $error("steer code set without display code");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("job pushed into full queue");

endmodule
